// File: rtl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// chacha_pkg: shared types, constants and round function
// Word formats, register indexes and the ChaCha half quarter-round.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int FIFO_DEPTH        = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_CTR = 3'd6;

  localparam logic [31:0] START_CTR_RST = 32'd1;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_call;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_word_t;

  // queue entry: input word tagged with its keystream byte position
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_call;
    logic [5:0] pos;
  } ent_t;

  typedef struct packed {
    logic valid;
    ent_t ent;
  } head_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } key_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [15:0][31:0] words;
  } ks_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // One half of a quarter-round: rotations 16/12 in the first half, 8/7 in the second.
  function automatic qr_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d,
                                  input logic second);
    qr_t         r;
    logic [31:0] a1;
    logic [31:0] d1;
    logic [31:0] c1;
    logic [31:0] b1;
    a1 = a + b;
    d1 = d ^ a1;
    d1 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
    c1 = c + d1;
    b1 = b ^ c1;
    b1 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    r.a = a1;
    r.b = b1;
    r.c = c1;
    r.d = d1;
    return r;
  endfunction

endpackage

// File: rtl/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher: ChaCha20 byte stream cipher, 96-bit nonce
// Each word is XORed with the next keystream byte; blocks come from a
// prefetching round unit.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  -----------------------------------
//  input    push / full             in_word_i  (data_byte, end_of_call)
//  result   empty / pop             out_word_o (result_byte, result_last)
//  config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One word per cycle within a block while the result side is not stalled.
//  The round unit loads the state, runs half a round per cycle and does the
//  final add. A block is started the cycle after the previous one is taken,
//  so short calls ending early wait on the round unit. After reset or any
//  config write the first result waits for a whole block to be built.
//  A stalled result side backs up through the 4-word queue.
//
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input word channel
  input  logic                                push,
  output logic                                full,
  input  chacha_pkg::in_word_t                in_word_i,
  // result word channel
  output logic                                empty,
  input  logic                                pop,
  output chacha_pkg::out_word_t               out_word_o,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // key and nonce registers; start counter lives in the core's counter
  chacha_pkg::key_cfg_t cfg_q;
  logic                 cfg_wr;
  logic                 ctr_load;
  chacha_pkg::head_t    head;
  logic                 head_pop;
  chacha_pkg::ks_t      ks_blk;
  logic                 ks_take;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign ctr_load    = cfg_wr && (cfg_index_i == chacha_pkg::REG_START_CTR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        chacha_pkg::REG_KEY_0:    cfg_q.key[1:0]   <= cfg_data_i;
        chacha_pkg::REG_KEY_1:    cfg_q.key[3:2]   <= cfg_data_i;
        chacha_pkg::REG_KEY_2:    cfg_q.key[5:4]   <= cfg_data_i;
        chacha_pkg::REG_KEY_3:    cfg_q.key[7:6]   <= cfg_data_i;
        chacha_pkg::REG_NONCE_LO: cfg_q.nonce[1:0] <= cfg_data_i;
        chacha_pkg::REG_NONCE_HI: cfg_q.nonce[2]   <= cfg_data_i[31:0];
        default: begin
          // start counter is handled in the core; unknown indexes ignored
        end
      endcase
    end
  end

  chacha_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .clr_pos_i  (ctr_load),
    .head_pop_i (head_pop),
    .head_o     (head)
  );

  // any config write drops the prefetched block so it is rebuilt
  // with the new key, nonce or counter
  chacha_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .flush_i    (cfg_wr),
    .ctr_load_i (ctr_load),
    .ctr_val_i  (cfg_data_i[31:0]),
    .take_i     (ks_take),
    .ks_o       (ks_blk)
  );

  chacha_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_pop_o (head_pop),
    .ks_i       (ks_blk),
    .take_o     (ks_take),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  // a block is only switched in when one is ready
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_take |-> ks_blk.valid)
    else $error("keystream block taken while none ready");

  // mid-block words never wait on the round unit
  a_mid_block_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && head.valid && (head.ent.pos != '0)) |=> !empty)
    else $error("mid-block word stalled with free result register");

  // a config write always discards the prefetched block
  a_cfg_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !ks_blk.valid)
    else $error("prefetched block survived a config write");

endmodule

// File: rtl/chacha_front.sv
// ----------------------------------------------------------------------------
// chacha_front: input side
// Accepts words, tags each with its byte position, queues them for the back.
// ----------------------------------------------------------------------------
module chacha_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  chacha_pkg::in_word_t in_word_i,
  input  logic                 clr_pos_i,
  input  logic                 head_pop_i,
  output chacha_pkg::head_t    head_o
);

  localparam int PTR_W = $clog2(chacha_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(chacha_pkg::FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(chacha_pkg::FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(chacha_pkg::FIFO_DEPTH);

  chacha_pkg::ent_t ent_q [chacha_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [5:0]       pos_q, pos_d;
  logic             wr_en;
  logic             rd_en;

  assign full   = (cnt_q == CNT_FULL);
  assign wr_en  = push && !full;
  assign rd_en  = head_pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.ent   = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      pos_d    = in_word_i.end_of_call ? '0 : pos_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
    // counter reload restarts the block
    if (clr_pos_i) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_q[wr_ptr_q].data_byte   <= in_word_i.data_byte;
      ent_q[wr_ptr_q].end_of_call <= in_word_i.end_of_call;
      ent_q[wr_ptr_q].pos         <= pos_q;
    end
  end

endmodule

// File: rtl/chacha_core.sv
// ----------------------------------------------------------------------------
// chacha_core: keystream block generator
// Iterative round unit, half a round per cycle, one block held ahead.
// ----------------------------------------------------------------------------
module chacha_core #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chacha_pkg::key_cfg_t cfg_i,
  input  logic                 flush_i,
  input  logic                 ctr_load_i,
  input  logic [31:0]          ctr_val_i,
  input  logic                 take_i,
  output chacha_pkg::ks_t      ks_o
);

  localparam int STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              nxt_vld_q, nxt_vld_d;
  logic [31:0]       ctr_q, ctr_d;
  logic [15:0][31:0] w_q, w_step;
  logic [15:0][31:0] nxt_q;
  logic [15:0][31:0] init_w;
  logic              start;
  logic              half;
  logic              diag;

  assign init_w[3:0]   = chacha_pkg::SIGMA;
  assign init_w[11:4]  = cfg_i.key;
  assign init_w[12]    = ctr_q;
  assign init_w[15:13] = cfg_i.nonce;

  assign half  = step_q[0];
  assign diag  = step_q[1];
  assign start = (state_q == ST_IDLE) && !nxt_vld_q && !flush_i;

  // four independent lanes: columns or diagonals
  always_comb begin
    logic [1:0]        lane;
    logic [3:0]        ia;
    logic [3:0]        ib;
    logic [3:0]        ic;
    logic [3:0]        id;
    chacha_pkg::qr_t   qr;
    w_step = w_q;
    for (int l = 0; l < 4; l++) begin
      lane = 2'(l);
      ia   = {2'b00, lane};
      ib   = {2'b01, lane + {1'b0, diag}};
      ic   = {2'b10, lane + {diag, 1'b0}};
      id   = {2'b11, lane + {diag, diag}};
      qr   = chacha_pkg::qr_half(w_q[ia], w_q[ib], w_q[ic], w_q[id], half);
      w_step[ia] = qr.a;
      w_step[ib] = qr.b;
      w_step[ic] = qr.c;
      w_step[id] = qr.d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    nxt_vld_d = nxt_vld_q;
    ctr_d     = ctr_q;
    if (flush_i) begin
      state_d   = ST_IDLE;
      nxt_vld_d = 1'b0;
      if (ctr_load_i) begin
        ctr_d = ctr_val_i;
      end
    end else begin
      if (take_i) begin
        nxt_vld_d = 1'b0;
        ctr_d     = ctr_q + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_d = ST_RUN;
            step_d  = '0;
          end
        end
        ST_RUN: begin
          step_d = step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            state_d = ST_ADD;
          end
        end
        ST_ADD: begin
          state_d   = ST_IDLE;
          nxt_vld_d = 1'b1;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      nxt_vld_q <= 1'b0;
      ctr_q     <= chacha_pkg::START_CTR_RST;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      nxt_vld_q <= nxt_vld_d;
      ctr_q     <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      w_q <= init_w;
    end else if (state_q == ST_RUN) begin
      w_q <= w_step;
    end
    if (state_q == ST_ADD) begin
      for (int i = 0; i < 16; i++) begin
        nxt_q[i] <= w_q[i] + init_w[i];
      end
    end
  end

  assign ks_o.valid = nxt_vld_q;
  assign ks_o.words = nxt_q;

endmodule

// File: rtl/chacha_back.sv
// ----------------------------------------------------------------------------
// chacha_back: keystream combine and result register
// Switches to the prefetched block at position zero, XORs, holds the result.
// ----------------------------------------------------------------------------
module chacha_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chacha_pkg::head_t     head_i,
  output logic                  head_pop_o,
  input  chacha_pkg::ks_t       ks_i,
  output logic                  take_o,
  output logic                  empty,
  input  logic                  pop,
  output chacha_pkg::out_word_t out_word_o
);

  logic [15:0][31:0]     cur_q;
  logic                  out_vld_q;
  chacha_pkg::out_word_t out_q;
  logic                  out_free;
  logic                  new_blk;
  logic                  go;
  logic [31:0]           ks_word;
  logic [31:0]           ks_shift;

  assign out_free = !out_vld_q || pop;
  assign new_blk  = (head_i.ent.pos == '0);
  assign go       = head_i.valid && out_free && (!new_blk || ks_i.valid);

  assign head_pop_o = go;
  assign take_o     = go && new_blk;

  // byte 0 of a new block comes straight from the prefetched block
  assign ks_word  = new_blk ? ks_i.words[0] : cur_q[head_i.ent.pos[5:2]];
  assign ks_shift = ks_word >> {head_i.ent.pos[1:0], 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cur_q <= ks_i.words;
    end
    if (go) begin
      out_q.result_byte <= head_i.ent.data_byte ^ ks_shift[7:0];
      out_q.result_last <= head_i.ent.end_of_call;
    end
  end

  assign empty      = !out_vld_q;
  assign out_word_o = out_q;

endmodule
